// File: hdl/ordma_pkg.sv
// ----------------------------------------------------------------------------
// ordma_pkg
// Shared types, codes and sizes of the overwriting transmit ring buffer.
// ----------------------------------------------------------------------------
package ordma_pkg;

  // Ring geometry and burst limit
  localparam int BUF_DEPTH = 1024;
  localparam int BURST_MAX = 255;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  // Width that holds an index sum, an available byte count and the depth itself
  localparam int SUM_W     = ((IDX_W + 1 > 8) ? IDX_W + 1 : 8) + 1;

  // Fixed field widths of the channels
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int START_W  = 10;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DONE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                burst_valid;
    logic [START_W-1:0]  burst_start;
    logic [BYTE_W-1:0]   burst_len;
    logic                burst_abort;
    logic                is_full;
  } result_t;

  // Byte store write request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

endpackage

// File: hdl/ordma_if.sv
// ----------------------------------------------------------------------------
// ordma channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ordma_req_if;
  logic                                valid;
  logic                                ready;
  logic [ordma_pkg::FUNC_W-1:0]        func;
  logic [ordma_pkg::BYTE_W-1:0]        data_byte;
  logic                                first_byte;
  logic                                last_byte;
  logic [ordma_pkg::LEN_W-1:0]         msg_len;
  logic [ordma_pkg::BYTE_W-1:0]        done_len;

  modport source (output valid, func, data_byte, first_byte, last_byte, msg_len, done_len,
                  input ready);
  modport sink   (input valid, func, data_byte, first_byte, last_byte, msg_len, done_len,
                  output ready);
endinterface

interface ordma_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [ordma_pkg::STATUS_W-1:0]      status;
  logic                                burst_valid;
  logic [ordma_pkg::START_W-1:0]       burst_start;
  logic [ordma_pkg::BYTE_W-1:0]        burst_len;
  logic                                burst_abort;
  logic                                is_full;

  modport source (output valid, status, burst_valid, burst_start, burst_len, burst_abort,
                  is_full, input ready);
  modport sink   (input valid, status, burst_valid, burst_start, burst_len, burst_abort,
                  is_full, output ready);
endinterface

interface ordma_cfg_if;
  logic valid;
  logic ready;
  logic tx_enable;

  modport source (output valid, tx_enable, input ready);
  modport sink   (input valid, tx_enable, output ready);
endinterface

// File: hdl/ordma_store.sv
// ----------------------------------------------------------------------------
// ordma_store
// Synchronous single-port byte store of the ring, one write per cycle.
// ----------------------------------------------------------------------------
module ordma_store (
  input  logic                 clk,
  input  ordma_pkg::store_wr_t wr
);

  logic [ordma_pkg::BYTE_W-1:0] mem [ordma_pkg::BUF_DEPTH];

  // Store the byte at the write pointer
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

endmodule

// File: hdl/ordma_ctrl.sv
// ----------------------------------------------------------------------------
// ordma_ctrl
// Ring pointers, full/sending/discard flags and burst issue logic.
// ----------------------------------------------------------------------------
module ordma_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  logic                                cfg_tx_enable,
  input  logic                                accept,
  input  logic [ordma_pkg::FUNC_W-1:0]        func,
  input  logic [ordma_pkg::BYTE_W-1:0]        data_byte,
  input  logic                                first_byte,
  input  logic                                last_byte,
  input  logic [ordma_pkg::LEN_W-1:0]         msg_len,
  input  logic [ordma_pkg::BYTE_W-1:0]        done_len,
  output ordma_pkg::result_t                  result,
  output ordma_pkg::store_wr_t                store_wr
);

  localparam int IW = ordma_pkg::IDX_W;
  localparam int SW = ordma_pkg::SUM_W;

  logic          tx_enable;
  logic [IW-1:0] write_index, write_index_next;
  logic [IW-1:0] send_index, send_index_next;
  logic          full_flag, full_flag_next;
  logic          sending, sending_next;
  logic          discarding, discarding_next;

  logic          take;
  logic          issue_ok;
  logic [IW-1:0] widx_inc;
  logic [SW-1:0] done_sum;
  logic [SW-1:0] avail;
  logic [SW-1:0] burst_cnt;

  // Next pointer and flag values plus the result of this item
  always_comb begin
    write_index_next = write_index;
    send_index_next  = send_index;
    full_flag_next   = full_flag;
    sending_next     = sending;
    discarding_next  = discarding;
    result           = '0;
    take             = 1'b0;
    issue_ok         = 1'b0;
    widx_inc         = (write_index == IW'(ordma_pkg::BUF_DEPTH - 1)) ? '0
                                                                       : write_index + 1'b1;
    done_sum         = SW'(send_index) + SW'(done_len);

    case (func)
      ordma_pkg::FUNC_WRITE: begin
        take = 1'b1;
        if (!tx_enable) begin
          result.status = ordma_pkg::ST_DISABLED;
          if (first_byte) begin
            discarding_next = 1'b1;
          end
          take = 1'b0;
        end else if (first_byte) begin
          if (SW'(msg_len) >= SW'(ordma_pkg::BUF_DEPTH) || msg_len[ordma_pkg::LEN_W-1:0] !=
              ordma_pkg::LEN_W'(SW'(msg_len))) begin
            result.status   = ordma_pkg::ST_TOO_LONG;
            discarding_next = 1'b1;
            take            = 1'b0;
          end else begin
            discarding_next = 1'b0;
          end
        end else if (discarding) begin
          take = 1'b0;
        end
        if (take) begin
          write_index_next = widx_inc;
          if (full_flag || widx_inc == send_index) begin
            send_index_next = widx_inc;
            full_flag_next  = 1'b1;
            if (sending) begin
              result.burst_abort = 1'b1;
              sending_next       = 1'b0;
            end
          end
          issue_ok = last_byte;
        end
      end
      ordma_pkg::FUNC_DONE: begin
        if (sending) begin
          send_index_next = (done_sum >= SW'(ordma_pkg::BUF_DEPTH)) ? '0 : IW'(done_sum);
          if (done_len != '0) begin
            full_flag_next = 1'b0;
          end
          sending_next = 1'b0;
          issue_ok     = 1'b1;
        end
      end
      ordma_pkg::FUNC_FLUSH: begin
        result.burst_abort = sending;
        sending_next       = 1'b0;
        write_index_next   = '0;
        send_index_next    = '0;
        full_flag_next     = 1'b0;
        discarding_next    = 1'b0;
      end
      default: begin
      end
    endcase

    // Issue the next burst from the send pointer over contiguous unsent bytes
    avail = (write_index_next > send_index_next)
          ? SW'(write_index_next) - SW'(send_index_next)
          : SW'(ordma_pkg::BUF_DEPTH) - SW'(send_index_next);
    burst_cnt = (avail > SW'(ordma_pkg::BURST_MAX)) ? SW'(ordma_pkg::BURST_MAX) : avail;
    if (issue_ok && tx_enable && !sending_next &&
        !(write_index_next == send_index_next && !full_flag_next)) begin
      sending_next       = 1'b1;
      result.burst_valid = 1'b1;
      result.burst_start = ordma_pkg::START_W'(send_index_next);
      result.burst_len   = ordma_pkg::BYTE_W'(burst_cnt);
    end

    result.is_full = full_flag_next;
  end

  // Store write for accepted bytes
  assign store_wr.en   = accept && take;
  assign store_wr.addr = write_index;
  assign store_wr.data = data_byte;

  // Advance pointers and flags on an accepted item; take config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_enable   <= 1'b0;
      write_index <= '0;
      send_index  <= '0;
      full_flag   <= 1'b0;
      sending     <= 1'b0;
      discarding  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        tx_enable <= cfg_tx_enable;
      end
      if (accept) begin
        write_index <= write_index_next;
        send_index  <= send_index_next;
        full_flag   <= full_flag_next;
        sending     <= sending_next;
        discarding  <= discarding_next;
      end
    end
  end

endmodule

// File: hdl/overwrite_ring_dma_tx_core.sv
// ----------------------------------------------------------------------------
// overwrite_ring_dma_tx_core
// Transmit ring buffer that overwrites its oldest unsent bytes and issues DMA bursts.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per handshake: a message byte write, a burst-complete
//   event (with the byte count sent) or a flush. Every accepted item gives exactly
//   one rsp item with a status, an optional new burst (start index and length),
//   an abort flag for the burst in flight, and the full flag.
//   cfg writes tx_enable; write it only while no item is in flight.
// Response and throughput:
//   An accepted item's response is presented in the cycle after it is accepted,
//   from the response register. One item per cycle is sustained while rsp.ready
//   is high; the registered pointer update and the one-port byte store write allow it.
// Reset:
//   rst (synchronous, active high) clears the pointers, flags and tx_enable and
//   empties the response register. Stored bytes are not cleared.
// Receiver stall:
//   While rsp.ready is low and a response is pending, req.ready drops, so no
//   item is lost; a new item is taken in the same cycle the pending one leaves.
// ----------------------------------------------------------------------------
module overwrite_ring_dma_tx_core (
  input  logic clk,
  input  logic rst,
  ordma_req_if.sink   req,
  ordma_rsp_if.source rsp,
  ordma_cfg_if.sink   cfg
);

  logic                 accept;
  logic                 rsp_valid;
  ordma_pkg::result_t   result;
  ordma_pkg::result_t   rsp_data;
  ordma_pkg::store_wr_t store_wr;

  // Take a new item when the response register is empty or drains now
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  ordma_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg.valid),
    .cfg_tx_enable (cfg.tx_enable),
    .accept        (accept),
    .func          (req.func),
    .data_byte     (req.data_byte),
    .first_byte    (req.first_byte),
    .last_byte     (req.last_byte),
    .msg_len       (req.msg_len),
    .done_len      (req.done_len),
    .result        (result),
    .store_wr      (store_wr)
  );

  ordma_store u_store (
    .clk (clk),
    .wr  (store_wr)
  );

  // Hold the response until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_data.status;
  assign rsp.burst_valid = rsp_data.burst_valid;
  assign rsp.burst_start = rsp_data.burst_start;
  assign rsp.burst_len   = rsp_data.burst_len;
  assign rsp.burst_abort = rsp_data.burst_abort;
  assign rsp.is_full     = rsp_data.is_full;

`ifndef SYNTHESIS
  // Every accepted item leaves a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("no response after accepted item");

  // An issued burst always comes with an ok status and a nonzero length
  a_burst_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.burst_valid |-> rsp_data.status == ordma_pkg::ST_OK &&
      rsp_data.burst_len != '0)
    else $error("burst issued with bad status or zero length");

  // A rejected write never stores a byte
  a_reject_no_store: assert property (@(posedge clk) disable iff (rst)
    accept && (result.status == ordma_pkg::ST_DISABLED ||
               result.status == ordma_pkg::ST_TOO_LONG) |-> !store_wr.en)
    else $error("rejected byte written to the store");
`endif

endmodule
